### rtl/modbus_rtu_response_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus RTU response decoder
// Checks are clocked on clock and held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_RESPONSE_DECODER_TOP_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define MRD_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mrd: same-cycle check failed");

// Next-cycle implication.
`define MRD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mrd: next-cycle check failed");

`endif

### rtl/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg
// Widths, codes and the CRC-16/MODBUS byte update for the response decoder.
// ----------------------------------------------------------------------------
package mrd_pkg;

   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 16;
   localparam int STATUS_W = 3;
   localparam int QTY_W    = 4;
   localparam int VALUE_W  = 33;
   localparam int IDX_W    = 3;
   localparam int KIND_W   = 2;

   // Only the first sixteen data bytes are ever decoded.
   localparam int DATA_USED  = 16;
   localparam int DATA_IDX_W = $clog2(DATA_USED);
   localparam int WORDS_USED = DATA_USED / 2;

   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [QTY_W-1:0] qty_type;
   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [DATA_USED-1:0][BYTE_W-1:0] data_bank_type;
   typedef logic [WORDS_USED-1:0][WORD_W-1:0] word_bank_type;

   // Status codes
   localparam status_type ST_OK           = 3'd0;
   localparam status_type ST_TOO_SHORT    = 3'd1;
   localparam status_type ST_CRC_ERROR    = 3'd2;
   localparam status_type ST_EXCEPTION    = 3'd3;
   localparam status_type ST_OVERFLOW     = 3'd4;
   localparam status_type ST_DATA_SHORT   = 3'd5;
   localparam status_type ST_UNKNOWN_TYPE = 3'd6;
   localparam status_type ST_BAD_FUNCTION = 3'd7;

   // Quantity codes
   localparam qty_type Q_VOLT        = 4'd0;
   localparam qty_type Q_CURRENT     = 4'd1;
   localparam qty_type Q_POWER       = 4'd2;
   localparam qty_type Q_PF          = 4'd3;
   localparam qty_type Q_FREQ        = 4'd4;
   localparam qty_type Q_ENERGY      = 4'd5;
   localparam qty_type Q_METER_RELAY = 4'd6;
   localparam qty_type Q_HUMID       = 4'd7;
   localparam qty_type Q_TEMP        = 4'd8;
   localparam qty_type Q_RELAY       = 4'd9;

   // Result plan kinds
   localparam kind_type KIND_ERROR   = 2'd0;
   localparam kind_type KIND_RELAY   = 2'd1;
   localparam kind_type KIND_METER   = 2'd2;
   localparam kind_type KIND_CLIMATE = 2'd3;

   // Last result index of each plan
   localparam logic [IDX_W-1:0] SINGLE_LAST_IDX  = 3'd0;
   localparam logic [IDX_W-1:0] METER_LAST_IDX   = 3'd6;
   localparam logic [IDX_W-1:0] CLIMATE_LAST_IDX = 3'd1;

   // Device types
   localparam logic [BYTE_W-1:0] DEV_METER   = 8'd2;
   localparam logic [BYTE_W-1:0] DEV_CLIMATE = 8'd3;
   localparam logic [BYTE_W-1:0] DEV_RELAY   = 8'd4;

   // Function codes
   localparam logic [BYTE_W-1:0] FUNC_READ_COILS = 8'h01;
   localparam logic [BYTE_W-1:0] FUNC_READ_HOLD  = 8'h03;
   localparam logic [BYTE_W-1:0] FUNC_READ_INPUT = 8'h04;
   localparam int                FUNC_EXC_BIT    = 7;

   // Minimum byte counts
   localparam logic [BYTE_W-1:0] METER_MIN_BC   = 8'd16;
   localparam logic [BYTE_W-1:0] CLIMATE_MIN_BC = 8'd4;
   localparam logic [BYTE_W-1:0] RELAY_MIN_BC   = 8'd1;

   localparam logic [WORD_W-1:0] RELAY_ON_WORD = 16'h0055;

   // Divide by ten: floor(x * 52429 / 2^19) is exact for x below 2^17.
   localparam logic [WORD_W-1:0] PF_RECIP = 16'd52429;
   localparam int                PF_SHIFT = 19;
   localparam int                PF_W     = 14;

   localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

   function automatic logic [WORD_W-1:0] crc_feed(input logic [WORD_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
      logic [WORD_W-1:0] c;
      c = crc_in ^ {8'h00, data};
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // CRC one byte ahead of the running value, as it stands after reset.
   localparam logic [WORD_W-1:0] CRC_AHEAD_RESET = crc_feed(CRC_INIT, 8'h00);

endpackage

### rtl/mrd_req_if.sv
// ----------------------------------------------------------------------------
// mrd_req_if
// Byte channel into the decoder: one frame byte and its end marker per item.
// ----------------------------------------------------------------------------
interface mrd_req_if;
   import mrd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_byte;
   logic              end_of_frame;

   modport source (output valid, output frame_byte, output end_of_frame, input ready);
   modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

### rtl/mrd_rsp_if.sv
// ----------------------------------------------------------------------------
// mrd_rsp_if
// Result channel out of the decoder: one decoded value or error per item.
// ----------------------------------------------------------------------------
interface mrd_rsp_if;
   import mrd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic [QTY_W-1:0]          quantity;
   logic signed [VALUE_W-1:0] value;
   logic [BYTE_W-1:0]         slave_address;
   logic                      last_result;

   modport source (output valid, output status, output quantity, output value,
                   output slave_address, output last_result, input ready);
   modport sink   (input valid, input status, input quantity, input value,
                   input slave_address, input last_result, output ready);
endinterface

### rtl/modbus_rtu_response_decoder_top.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_decoder_top
// The final byte loads the plan registers; the first result then goes into the output register.
// Throughput: one byte per cycle; a frame gives 1, 2 or 7 results, one per cycle while ready.
// A final byte waits in the input register while the previous frame still emits.
// Reset (synchronous, active high) clears control state and device_type to 0.
// ----------------------------------------------------------------------------
`include "modbus_rtu_response_decoder_top_assert.svh"

module modbus_rtu_response_decoder_top (
   input  logic                       clock,
   input  logic                       reset,
   mrd_req_if.sink                    req_ch,
   mrd_rsp_if.source                  rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [mrd_pkg::BYTE_W-1:0] csr_wr_data
);
   import mrd_pkg::*;

   // ------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------
   logic [BYTE_W-1:0] dev_type_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_type_ff <= '0;
      end else if (csr_wr_en) begin
         dev_type_ff <= csr_wr_data;
      end
   end

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_eof_ff;

   // Emitter handshake terms (emitter defined below)
   logic              busy_ff;
   logic [IDX_W-1:0]  emit_idx_ff;
   logic [IDX_W-1:0]  last_idx_ff;
   logic              rsp_valid_ff;
   logic              emit_fire;
   logic              emit_last;
   logic              load_ok;
   logic              proc_go;
   logic              plan_load;
   logic              req_ready;

   // A result moves into the output register when it is empty or being taken.
   assign emit_fire = busy_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign emit_last = (emit_idx_ff == last_idx_ff);
   // A new plan may enter when the emitter is idle or hands out its last result now.
   assign load_ok   = !busy_ff || (emit_fire && emit_last);
   // Ordinary bytes always advance; a final byte advances only when a plan can load.
   assign proc_go   = in_valid_ff && (!in_eof_ff || load_ok);
   assign plan_load = proc_go && in_eof_ff;
   assign req_ready = !in_valid_ff || proc_go;
   assign req_ch.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_ch.valid) begin
         in_byte_ff <= req_ch.frame_byte;
         in_eof_ff  <= req_ch.end_of_frame;
      end
   end

   // ------------------------------------------------------------------
   // Frame state
   // crc_ahead_ff holds the CRC with the older of the two held-back bytes
   // already folded in, so the final check needs only a compare.
   // ------------------------------------------------------------------
   logic [WORD_W-1:0]     byte_cnt_ff;
   logic [WORD_W-1:0]     crc_ahead_ff;
   logic [BYTE_W-1:0]     prev_byte_ff;
   logic [BYTE_W-1:0]     addr_ff;
   logic [BYTE_W-1:0]     func_ff;
   logic [BYTE_W-1:0]     count_ff;
   data_bank_type         data_ff;

   logic [WORD_W-1:0]     crc_base;
   logic [WORD_W-1:0]     wr_off;
   logic                  data_hit;
   logic [DATA_IDX_W-1:0] data_idx;
   data_bank_type         data_view;

   assign crc_base = (byte_cnt_ff >= 16'd2) ? crc_ahead_ff : CRC_INIT;
   assign wr_off   = byte_cnt_ff - 16'd3;
   assign data_hit = (byte_cnt_ff >= 16'd3) && (wr_off < WORD_W'(DATA_USED));
   assign data_idx = wr_off[DATA_IDX_W-1:0];

   // Data bank as it stands with the current byte written.
   always_comb begin
      data_view = data_ff;
      if (data_hit) begin
         data_view[data_idx] = in_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_go && data_hit) begin
         data_ff[data_idx] <= in_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff  <= '0;
         crc_ahead_ff <= CRC_AHEAD_RESET;
         prev_byte_ff <= '0;
         addr_ff      <= '0;
         func_ff      <= '0;
         count_ff     <= '0;
      end else if (proc_go) begin
         if (in_eof_ff) begin
            // Clear for the next frame.
            byte_cnt_ff  <= '0;
            crc_ahead_ff <= CRC_AHEAD_RESET;
            prev_byte_ff <= '0;
            addr_ff      <= '0;
            func_ff      <= '0;
            count_ff     <= '0;
         end else begin
            if (byte_cnt_ff != '1) begin
               byte_cnt_ff <= byte_cnt_ff + 16'd1;
            end
            crc_ahead_ff <= crc_feed(crc_base, prev_byte_ff);
            prev_byte_ff <= in_byte_ff;
            if (byte_cnt_ff == 16'd0) begin
               addr_ff <= in_byte_ff;
            end
            if (byte_cnt_ff == 16'd1) begin
               func_ff <= in_byte_ff;
            end
            if (byte_cnt_ff == 16'd2) begin
               count_ff <= in_byte_ff;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Frame checks on the final byte, in priority order
   // ------------------------------------------------------------------
   logic              crc_ok;
   logic              func_known;
   logic [WORD_W-1:0] count_plus4;
   status_type        chk_status;
   kind_type          chk_kind;
   logic [IDX_W-1:0]  chk_last_idx;
   logic [BYTE_W-1:0] frame_addr;

   assign crc_ok      = (crc_ahead_ff == {in_byte_ff, prev_byte_ff});
   assign func_known  = (func_ff == FUNC_READ_HOLD) || (func_ff == FUNC_READ_INPUT) ||
                        (func_ff == FUNC_READ_COILS);
   assign count_plus4 = WORD_W'(count_ff) + 16'd4;
   // A one-byte frame still reports its only byte as the address.
   assign frame_addr  = (byte_cnt_ff == 16'd0) ? in_byte_ff : addr_ff;

   always_comb begin
      chk_status = ST_OK;
      chk_kind   = KIND_ERROR;
      if (byte_cnt_ff < 16'd3) begin
         chk_status = ST_TOO_SHORT;
      end else if (!crc_ok) begin
         chk_status = ST_CRC_ERROR;
      end else if (func_ff[FUNC_EXC_BIT]) begin
         chk_status = ST_EXCEPTION;
      end else if (!func_known) begin
         chk_status = ST_BAD_FUNCTION;
      end else if (byte_cnt_ff < 16'd4) begin
         chk_status = ST_TOO_SHORT;
      end else if (count_plus4 > byte_cnt_ff) begin
         chk_status = ST_OVERFLOW;
      end else if (func_ff == FUNC_READ_COILS) begin
         if (dev_type_ff != DEV_RELAY) begin
            chk_status = ST_UNKNOWN_TYPE;
         end else if (count_ff < RELAY_MIN_BC) begin
            chk_status = ST_DATA_SHORT;
         end else begin
            chk_kind = KIND_RELAY;
         end
      end else if (dev_type_ff == DEV_METER) begin
         if (count_ff < METER_MIN_BC) begin
            chk_status = ST_DATA_SHORT;
         end else begin
            chk_kind = KIND_METER;
         end
      end else if (dev_type_ff == DEV_CLIMATE) begin
         if (count_ff < CLIMATE_MIN_BC) begin
            chk_status = ST_DATA_SHORT;
         end else begin
            chk_kind = KIND_CLIMATE;
         end
      end else begin
         chk_status = ST_UNKNOWN_TYPE;
      end
   end

   always_comb begin
      case (chk_kind)
         KIND_METER:   chk_last_idx = METER_LAST_IDX;
         KIND_CLIMATE: chk_last_idx = CLIMATE_LAST_IDX;
         default:      chk_last_idx = SINGLE_LAST_IDX;
      endcase
   end

   // ------------------------------------------------------------------
   // Emitter: holds a snapshot of the finished frame and hands out its
   // results one per cycle while the output register can take them, while the next frame streams in behind it.
   // ------------------------------------------------------------------
   kind_type          plan_kind_ff;
   status_type        plan_status_ff;
   logic [BYTE_W-1:0] plan_addr_ff;
   data_bank_type     plan_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         emit_idx_ff <= '0;
         last_idx_ff <= '0;
      end else if (plan_load) begin
         busy_ff     <= 1'b1;
         emit_idx_ff <= '0;
         last_idx_ff <= chk_last_idx;
      end else if (emit_fire) begin
         if (emit_last) begin
            busy_ff <= 1'b0;
         end else begin
            emit_idx_ff <= emit_idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (plan_load) begin
         plan_kind_ff   <= chk_kind;
         plan_status_ff <= chk_status;
         plan_addr_ff   <= frame_addr;
         plan_data_ff   <= data_view;
      end
   end

   // Big-endian 16-bit words of the snapshot.
   word_bank_type words;

   always_comb begin
      for (int k = 0; k < WORDS_USED; k++) begin
         words[k] = {plan_data_ff[2*k], plan_data_ff[2*k+1]};
      end
   end

   logic [19:0]          tenfold;
   logic [22:0]          power_val;
   logic [16:0]          pf_sum;
   logic [32:0]          pf_prod;
   logic [PF_W-1:0]      pf_val;
   logic signed [19:0]   temp_ext;
   logic signed [19:0]   temp_val;
   logic                 meter_relay;
   qty_type              res_qty;
   logic [VALUE_W-1:0]   res_value;

   assign tenfold     = 20'(words[0]) * 20'd10;
   assign power_val   = 23'(words[2]) * 23'd100;
   // Power factor: round half up to the nearest tenth.
   assign pf_sum      = 17'(words[3]) + 17'd5;
   assign pf_prod     = 33'(pf_sum) * 33'(PF_RECIP);
   assign pf_val      = pf_prod[PF_SHIFT +: PF_W];
   assign temp_ext    = {{4{words[1][WORD_W-1]}}, words[1]};
   assign temp_val    = temp_ext * 20'sd10;
   assign meter_relay = (words[7] == RELAY_ON_WORD);

   always_comb begin
      res_qty   = Q_VOLT;
      res_value = '0;
      case (plan_kind_ff)
         KIND_RELAY: begin
            res_qty   = Q_RELAY;
            res_value = VALUE_W'(plan_data_ff[0][0]);
         end
         KIND_CLIMATE: begin
            if (emit_idx_ff == 3'd0) begin
               res_qty   = Q_HUMID;
               res_value = VALUE_W'(tenfold);
            end else begin
               res_qty   = Q_TEMP;
               res_value = VALUE_W'(temp_val);
            end
         end
         KIND_METER: begin
            case (emit_idx_ff)
               3'd0: begin
                  res_qty   = Q_VOLT;
                  res_value = VALUE_W'(tenfold);
               end
               3'd1: begin
                  res_qty   = Q_CURRENT;
                  res_value = VALUE_W'(words[1]);
               end
               3'd2: begin
                  res_qty   = Q_POWER;
                  res_value = VALUE_W'(power_val);
               end
               3'd3: begin
                  res_qty   = Q_PF;
                  res_value = VALUE_W'(pf_val);
               end
               3'd4: begin
                  res_qty   = Q_FREQ;
                  res_value = VALUE_W'(words[4]);
               end
               3'd5: begin
                  res_qty   = Q_ENERGY;
                  res_value = VALUE_W'({words[5], words[6]});
               end
               default: begin
                  res_qty   = Q_METER_RELAY;
                  res_value = VALUE_W'(meter_relay);
               end
            endcase
         end
         default: begin
            // Error result: quantity and value stay zero.
            res_qty   = Q_VOLT;
            res_value = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   status_type         rsp_status_ff;
   qty_type            rsp_qty_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [BYTE_W-1:0]  rsp_addr_ff;
   logic               rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_status_ff <= plan_status_ff;
         rsp_qty_ff    <= res_qty;
         rsp_value_ff  <= res_value;
         rsp_addr_ff   <= plan_addr_ff;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.quantity      = rsp_qty_ff;
   assign rsp_ch.value         = $signed(rsp_value_ff);
   assign rsp_ch.slave_address = rsp_addr_ff;
   assign rsp_ch.last_result   = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   logic rsp_is_error;
   logic rsp_error_shape;

   assign rsp_is_error    = rsp_ch.valid && (rsp_ch.status != ST_OK);
   assign rsp_error_shape = rsp_ch.last_result && (rsp_ch.quantity == Q_VOLT) &&
                            (rsp_ch.value == '0);

   // An error result is always the single, final result of its frame.
   `MRD_ASSERT_IMP(a_error_single, rsp_is_error, rsp_error_shape)
   // The emit index never runs past the plan's last result.
   `MRD_ASSERT_IMP(a_idx_bound, busy_ff, emit_idx_ff <= last_idx_ff)
   // After the last result goes out with nothing queued, the emitter goes idle.
   `MRD_ASSERT_NEXT(a_emit_done, emit_fire && emit_last && !plan_load, !busy_ff)
   // A final byte that cannot load a plan holds back the input side.
   `MRD_ASSERT_IMP(a_eof_stall, in_valid_ff && in_eof_ff && !load_ok, !req_ch.ready)

endmodule

### tb/mrd_tb_pkg.sv
// ----------------------------------------------------------------------------
// mrd_tb_pkg
// Shared verification types: one decoded result and the CRC-16/MODBUS byte
// update used both to build frames and to predict the decoder's verdict.
// ----------------------------------------------------------------------------
package mrd_tb_pkg;
   import mrd_pkg::*;

   typedef struct packed {
      status_type                status;
      qty_type                   quantity;
      logic signed [VALUE_W-1:0] value;
      logic [BYTE_W-1:0]         slave_address;
      logic                      last_result;
   } decoded_result_type;

   function automatic logic [WORD_W-1:0] modbus_crc_byte(input logic [WORD_W-1:0] crc,
                                                         input logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] c;
      c = crc ^ WORD_W'(b);
      repeat (BYTE_W) c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
      return c;
   endfunction

endpackage

### tb/mrd_decode_checker.sv
// ----------------------------------------------------------------------------
// mrd_decode_checker
// Watches the byte and result channels and the device type register, keeps
// its own copy of the frame state, predicts the results of every frame and
// compares them in order with what the decoder emits.
// ----------------------------------------------------------------------------
module mrd_decode_checker (
   input  logic                       clock,
   input  logic                       reset,
   mrd_req_if                         req_ch,
   mrd_rsp_if                         rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [mrd_pkg::BYTE_W-1:0] csr_wr_data,
   output int                         fail_count,
   output int                         pending_count
);
   import mrd_pkg::*;
   import mrd_tb_pkg::*;

   logic [BYTE_W-1:0]  device_kind;
   logic [WORD_W-1:0]  byte_cnt;
   logic [WORD_W-1:0]  crc_acc;
   // The two newest bytes stay out of the CRC until the frame goes on.
   logic [BYTE_W-1:0]  lag_old;
   logic [BYTE_W-1:0]  lag_new;
   logic [BYTE_W-1:0]  addr_byte;
   logic [BYTE_W-1:0]  func_byte;
   logic [BYTE_W-1:0]  count_byte;
   logic [BYTE_W-1:0]  data_bytes [DATA_USED];
   decoded_result_type pending_results [$];
   int                 fails = 0;

   function automatic void clear_frame();
      byte_cnt   = '0;
      crc_acc    = CRC_INIT;
      lag_old    = '0;
      lag_new    = '0;
      addr_byte  = '0;
      func_byte  = '0;
      count_byte = '0;
   endfunction

   function automatic logic [WORD_W-1:0] data_word(input int i);
      return {data_bytes[i], data_bytes[i+1]};
   endfunction

   function automatic void add_result(input status_type st, input qty_type q, input longint v);
      decoded_result_type r;
      r.status        = st;
      r.quantity      = q;
      r.value         = VALUE_W'(v);
      r.slave_address = addr_byte;
      r.last_result   = 1'b0;
      pending_results.push_back(r);
   endfunction

   // Give the frame's status; on success queue its decoded values.
   function automatic status_type judge_frame(input int unsigned len,
                                              input logic [BYTE_W-1:0] last_byte);
      int unsigned bc;
      bc = 32'(count_byte);
      if (len < 4) return ST_TOO_SHORT;
      if (modbus_crc_byte(crc_acc, lag_old) != {last_byte, lag_new}) return ST_CRC_ERROR;
      if (func_byte[FUNC_EXC_BIT]) return ST_EXCEPTION;
      if (!(func_byte inside {FUNC_READ_COILS, FUNC_READ_HOLD, FUNC_READ_INPUT}))
         return ST_BAD_FUNCTION;
      if (len < 5) return ST_TOO_SHORT;
      if (5 + bc > len) return ST_OVERFLOW;
      if (func_byte == FUNC_READ_COILS) begin
         if (device_kind != DEV_RELAY) return ST_UNKNOWN_TYPE;
         if (bc < RELAY_MIN_BC) return ST_DATA_SHORT;
         add_result(ST_OK, Q_RELAY, longint'(data_bytes[0][0]));
         return ST_OK;
      end
      if (device_kind == DEV_METER) begin
         if (bc < METER_MIN_BC) return ST_DATA_SHORT;
         add_result(ST_OK, Q_VOLT, longint'(data_word(0)) * 10);
         add_result(ST_OK, Q_CURRENT, longint'(data_word(2)));
         add_result(ST_OK, Q_POWER, longint'(data_word(4)) * 100);
         add_result(ST_OK, Q_PF, (longint'(data_word(6)) + 5) / 10);
         add_result(ST_OK, Q_FREQ, longint'(data_word(8)));
         add_result(ST_OK, Q_ENERGY, longint'({data_word(10), data_word(12)}));
         add_result(ST_OK, Q_METER_RELAY, longint'(data_word(14) == RELAY_ON_WORD));
         return ST_OK;
      end
      if (device_kind == DEV_CLIMATE) begin
         if (bc < CLIMATE_MIN_BC) return ST_DATA_SHORT;
         add_result(ST_OK, Q_HUMID, longint'(data_word(0)) * 10);
         add_result(ST_OK, Q_TEMP, longint'(signed'(data_word(2))) * 10);
         return ST_OK;
      end
      return ST_UNKNOWN_TYPE;
   endfunction

   function automatic void absorb_byte(input logic [BYTE_W-1:0] b, input logic eof);
      int unsigned pos;
      status_type  st;
      pos = 32'(byte_cnt);
      if (pos == 0) addr_byte = b;
      else if (pos == 1) func_byte = b;
      else if (pos == 2) count_byte = b;
      else if (pos < 3 + DATA_USED) data_bytes[pos-3] = b;
      if (!eof) begin
         if (pos >= 2) crc_acc = modbus_crc_byte(crc_acc, lag_old);
         lag_old = lag_new;
         lag_new = b;
         if (byte_cnt != '1) byte_cnt++;
      end else begin
         st = judge_frame(pos + 1, b);
         if (st != ST_OK) add_result(st, Q_VOLT, 0);
         pending_results[pending_results.size()-1].last_result = 1'b1;
         clear_frame();
      end
   endfunction

   always @(posedge clock) begin
      decoded_result_type want;
      logic               bad;
      if (reset) begin
         device_kind = '0;
         clear_frame();
         pending_results.delete();
      end else begin
         if (csr_wr_en) device_kind = csr_wr_data;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: status %0d quantity %0d value %0d",
                      rsp_ch.status, rsp_ch.quantity, rsp_ch.value);
               fails++;
            end else begin
               want = pending_results.pop_front();
               bad  = 1'b0;
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                  bad = 1'b1;
               end
               if (rsp_ch.quantity !== want.quantity) begin
                  $error("quantity: expected %0d, got %0d", want.quantity, rsp_ch.quantity);
                  bad = 1'b1;
               end
               if (rsp_ch.value !== want.value) begin
                  $error("value: expected %0d, got %0d", want.value, rsp_ch.value);
                  bad = 1'b1;
               end
               if (rsp_ch.slave_address !== want.slave_address) begin
                  $error("slave_address: expected 0x%02h, got 0x%02h",
                         want.slave_address, rsp_ch.slave_address);
                  bad = 1'b1;
               end
               if (rsp_ch.last_result !== want.last_result) begin
                  $error("last_result: expected %0d, got %0d",
                         want.last_result, rsp_ch.last_result);
                  bad = 1'b1;
               end
               if (bad) fails++;
            end
         end
         if (req_ch.valid && req_ch.ready) absorb_byte(req_ch.frame_byte, req_ch.end_of_frame);
      end
      fail_count    <= fails;
      pending_count <= pending_results.size();
   end

endmodule

### tb/modbus_rtu_response_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_decoder_top_tb
// Feeds Modbus RTU response frames byte by byte into the decoder under
// several device types: a directed set of corner frames and a mix of random
// well-formed and broken frames. A checker beside the decoder predicts and
// compares results.
// ----------------------------------------------------------------------------
module modbus_rtu_response_decoder_top_tb;
   import mrd_pkg::*;
   import mrd_tb_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 64;

   // How the data bytes of a frame are filled.
   typedef enum int {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES,
      FILL_RELAY_ON
   } fill_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [BYTE_W-1:0] csr_wr_data = '0;

   mrd_req_if req_ch ();
   mrd_rsp_if rsp_ch ();

   int                fail_count;
   int                pending_count;
   int                cycle_count = 0;
   int                burst_left = 0;
   int                max_gap = 6;
   int                bytes_sent = 0;
   logic [BYTE_W-1:0] cur_device = '0;
   logic [BYTE_W-1:0] frame_q [$];

   // Receiver stall pattern state.
   int                stall_mode = 0;
   int                mode_left = 0;
   logic [15:0]       stall_pat = 16'h1;

   modbus_rtu_response_decoder_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mrd_decode_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Result side: switch between stall styles, each held for a random span -
   // always ready, coin flip, a rotating bit pattern, and mostly stalled.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(20, 200);
         stall_pat  <= 16'($urandom) | 16'h1;
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= 1'($urandom_range(0, 1));
         2: rsp_ch.ready <= stall_pat[cycle_count % 16];
         default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Offer one byte and hold it until taken. A new burst may open with a gap
   // during which valid drops; within a burst valid stays high.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eof);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, max_gap);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.valid        <= 1'b1;
      req_ch.frame_byte   <= b;
      req_ch.end_of_frame <= eof;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   // Drop valid and wait until every predicted result has come out, then
   // wait out the settle cycles so the decoder can show anything unexpected.
   task automatic settle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the device type; only called while the decoder is idle.
   task automatic set_device(input logic [BYTE_W-1:0] kind);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= kind;
      cur_device = kind;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [BYTE_W-1:0] fill_byte(input int k, input fill_mode_type fill);
      case (fill)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hFF;
         FILL_RELAY_ON: begin
            if (k == 14) return 8'h00;
            if (k == 15) return RELAY_ON_WORD[BYTE_W-1:0];
            return BYTE_W'($urandom_range(0, 255));
         end
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic fill_mode_type pick_fill();
      case ($urandom_range(0, 9))
         0: return FILL_ZERO;
         1: return FILL_ONES;
         2, 3: return FILL_RELAY_ON;
         default: return FILL_RANDOM;
      endcase
   endfunction

   // Lay out address, function, byte count and n_data data bytes.
   function automatic void build_frame(input logic [BYTE_W-1:0] addr,
                                       input logic [BYTE_W-1:0] func,
                                       input logic [BYTE_W-1:0] bc, input int n_data,
                                       input fill_mode_type fill);
      frame_q.delete();
      frame_q.push_back(addr);
      frame_q.push_back(func);
      frame_q.push_back(bc);
      for (int k = 0; k < n_data; k++) frame_q.push_back(fill_byte(k, fill));
   endfunction

   // Append the CRC, low byte first, optionally with one bit flipped, and
   // send the whole frame with the end marker on its last byte.
   task automatic send_with_crc(input bit bad_crc);
      logic [WORD_W-1:0] crc;
      int                n;
      crc = CRC_INIT;
      foreach (frame_q[k]) crc = modbus_crc_byte(crc, frame_q[k]);
      if (bad_crc) crc ^= WORD_W'(1) << $urandom_range(0, WORD_W - 1);
      frame_q.push_back(crc[7:0]);
      frame_q.push_back(crc[15:8]);
      n = frame_q.size();
      for (int k = 0; k < n; k++) send_byte(frame_q[k], k == n - 1);
   endtask

   // Raw random bytes with no CRC worth the name.
   task automatic send_noise(input int len);
      for (int k = 0; k < len; k++) send_byte(BYTE_W'($urandom_range(0, 255)), k == len - 1);
   endtask

   // One random frame, mostly well formed for the current device type.
   task automatic random_frame();
      int                kind;
      int                n_data;
      logic [BYTE_W-1:0] func;
      logic [BYTE_W-1:0] bc;
      bit                bad_crc;
      kind    = $urandom_range(0, 9);
      bad_crc = 1'b0;
      if (kind == 9) begin
         send_noise($urandom_range(1, 10));
      end else begin
         func = $urandom_range(0, 1) ? FUNC_READ_HOLD : FUNC_READ_INPUT;
         case (cur_device)
            DEV_METER:
               bc = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(17, 24)) :
                                                  METER_MIN_BC;
            DEV_CLIMATE: bc = BYTE_W'($urandom_range(4, 8));
            DEV_RELAY: begin
               func = FUNC_READ_COILS;
               bc   = BYTE_W'($urandom_range(1, 3));
            end
            default: begin
               if ($urandom_range(0, 2) == 0) func = FUNC_READ_COILS;
               bc = BYTE_W'($urandom_range(0, 20));
            end
         endcase
         n_data = int'(bc);
         // Break the frame in one of several ways.
         if (kind == 7) begin
            case ($urandom_range(0, 2))
               0: bc = bc + BYTE_W'($urandom_range(1, 4));
               1: begin
                  bc     = BYTE_W'($urandom_range(0, 3));
                  n_data = int'(bc);
               end
               default: bad_crc = 1'b1;
            endcase
         end
         if (kind == 8) func = BYTE_W'($urandom_range(0, 255));
         build_frame(BYTE_W'($urandom_range(0, 255)), func, bc, n_data, pick_fill());
         send_with_crc(bad_crc);
      end
   endtask

   initial begin
      int               start_bytes;
      int               dev_roll;
      logic [BYTE_W-1:0] next_device;

      // Drive the byte channel to a known level from the start.
      req_ch.valid        = 1'b0;
      req_ch.frame_byte   = '0;
      req_ch.end_of_frame = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ---- Directed frames, meter device ----
      set_device(DEV_METER);
      send_noise(1);                          // one byte: too short, address is that byte
      send_noise(3);                          // still under the minimum length
      frame_q.delete();                       // address and function only: too short
      frame_q.push_back(8'h11);
      frame_q.push_back(FUNC_READ_HOLD);
      send_with_crc(1'b0);
      build_frame(8'h01, FUNC_READ_HOLD, METER_MIN_BC, 16, FILL_RANDOM);
      send_with_crc(1'b0);
      build_frame(8'h00, FUNC_READ_HOLD, METER_MIN_BC, 16, FILL_ZERO);
      send_with_crc(1'b0);
      build_frame(8'hFF, FUNC_READ_INPUT, METER_MIN_BC, 16, FILL_ONES);
      send_with_crc(1'b0);
      build_frame(8'h22, FUNC_READ_HOLD, METER_MIN_BC, 16, FILL_RELAY_ON);
      send_with_crc(1'b0);
      build_frame(8'h23, FUNC_READ_INPUT, 8'd20, 20, FILL_RANDOM);   // bytes past the store
      send_with_crc(1'b0);
      build_frame(8'h24, FUNC_READ_HOLD, METER_MIN_BC, 16, FILL_RANDOM);
      send_with_crc(1'b1);                    // CRC mismatch
      build_frame(8'h25, FUNC_READ_HOLD | 8'h80, 8'd1, 0, FILL_RANDOM);
      send_with_crc(1'b0);                    // exception response
      build_frame(8'h26, 8'h10, 8'd2, 2, FILL_RANDOM);
      send_with_crc(1'b0);                    // unsupported function
      build_frame(8'h27, 8'h00, 8'd0, 0, FILL_RANDOM);
      send_with_crc(1'b0);
      build_frame(8'h28, FUNC_READ_HOLD, METER_MIN_BC, 10, FILL_RANDOM);
      send_with_crc(1'b0);                    // byte count runs past the frame
      build_frame(8'h29, FUNC_READ_HOLD, 8'd8, 8, FILL_RANDOM);
      send_with_crc(1'b0);                    // too few data bytes for a meter
      build_frame(8'h2A, FUNC_READ_COILS, 8'd1, 1, FILL_RANDOM);
      send_with_crc(1'b0);                    // coils on a meter: unknown type
      settle();

      // ---- Temperature/humidity device ----
      set_device(DEV_CLIMATE);
      build_frame(8'h31, FUNC_READ_INPUT, CLIMATE_MIN_BC, 4, FILL_RANDOM);
      send_with_crc(1'b0);
      build_frame(8'h32, FUNC_READ_HOLD, CLIMATE_MIN_BC, 4, FILL_ONES);
      send_with_crc(1'b0);                    // negative temperature, top humidity
      build_frame(8'h33, FUNC_READ_HOLD, 8'd2, 2, FILL_RANDOM);
      send_with_crc(1'b0);
      settle();

      // ---- Relay device ----
      set_device(DEV_RELAY);
      build_frame(8'h41, FUNC_READ_COILS, 8'd1, 1, FILL_ONES);
      send_with_crc(1'b0);
      build_frame(8'h42, FUNC_READ_COILS, 8'd1, 1, FILL_ZERO);
      send_with_crc(1'b0);
      build_frame(8'h43, FUNC_READ_COILS, 8'd0, 0, FILL_RANDOM);
      send_with_crc(1'b0);                    // empty coil data
      build_frame(8'h44, FUNC_READ_HOLD, 8'd4, 4, FILL_RANDOM);
      send_with_crc(1'b0);
      settle();

      // ---- Register extremes: unknown devices ----
      set_device(8'h00);
      build_frame(8'h51, FUNC_READ_HOLD, METER_MIN_BC, 16, FILL_RANDOM);
      send_with_crc(1'b0);
      settle();
      set_device(8'hFF);
      build_frame(8'h52, FUNC_READ_COILS, 8'd1, 1, FILL_RANDOM);
      send_with_crc(1'b0);
      settle();

      // ---- Random phases, each under its own device type and gap limit ----
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < RANDOM_ITEMS) begin
         dev_roll = $urandom_range(0, 7);
         case (dev_roll)
            0, 1: next_device = DEV_METER;
            2, 3: next_device = DEV_CLIMATE;
            4, 5: next_device = DEV_RELAY;
            6: next_device = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: next_device = BYTE_W'($urandom_range(0, 255));
         endcase
         set_device(next_device);
         max_gap = $urandom_range(0, 6);
         repeat ($urandom_range(4, 10)) begin
            if (bytes_sent - start_bytes < RANDOM_ITEMS) random_frame();
         end
         settle();
      end

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
